### rtl/trme_pkg.sv
// Package for the two-run merge engine: field widths, configuration register
// indexes, default parameter values and the packed transaction types.
// Used by the top level of the block and by the testbench; depends on nothing.
`default_nettype none

package trme_pkg;

  localparam int MEM_DEPTH_DEF   = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int IDX_W      = 6;
  localparam int LEN_W      = 7;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CALC_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN1_START  = 3'd0,
    CFG_RUN1_LENGTH = 3'd1,
    CFG_RUN2_START  = 3'd2,
    CFG_RUN2_LENGTH = 3'd3,
    CFG_DEST_START  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_MERGE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                     opcode;
    logic [IDX_W-1:0]         load_index;
    logic signed [DATA_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         dest_index;
    logic signed [DATA_W-1:0] out_value;
    logic                     last;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/trme_ram.sv
// Generic RAM with one write port and two read ports, read data registered.
// Used for the element store of the merge engine; depends on no package.
`default_nettype none

module trme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

### rtl/two_run_merge_engine_unit.sv
// Top level of the two-run merge engine: configuration registers, merge
// sequencer and output register. Depends on trme_pkg and trme_ram.
//
// Usage. A transaction is accepted at a rising edge with start high and busy
// low. A load transaction writes load_value into the element store at
// load_index in that cycle and returns nothing; busy stays low, so loads can
// follow one per cycle. A merge transaction walks the two runs set by the
// configuration registers and returns one result per merged element, one per
// cycle, each shown on out_item for exactly one cycle with out_valid high.
// The last result carries last set; an empty merge returns nothing.
// After a merge is accepted, busy stays high through a preparation state,
// which reduces dest_start below MEM_DEPTH (nothing to do at the default
// depth), and then, unless the merge is empty, through the merge state. The
// rate of one result per cycle is set by the single head compare and the two
// read ports of the store, which prefetch both run heads every cycle. The
// receiver cannot stall; results are never held back. Configuration is to be
// written through cfg_we, cfg_index and cfg_wdata only while the block is
// idle by the user; the block itself does not enforce it. Reset clears the
// configuration registers and the sequencer; the store is not cleared.
`default_nettype none

module two_run_merge_engine_unit #(
  parameter int MEM_DEPTH   = trme_pkg::MEM_DEPTH_DEF,
  parameter int VALUE_WIDTH = trme_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire trme_pkg::in_item_t                    in_item,
  output logic                                       out_valid,
  output trme_pkg::out_item_t                        out_item,
  input  wire logic                                  cfg_we,
  input  wire logic [trme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [trme_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import trme_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int CW = $clog2(MEM_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PREP  = 3'b010,
    ST_MERGE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] run1_start_r, run2_start_r, dest_start_r;
  logic [LEN_W-1:0] run1_length_r, run2_length_r;

  logic [CW-1:0]    a_r, a_nxt, b_r, b_nxt, ea_r, ea_nxt, eb_r, eb_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [IDX_W-1:0] d_r, d_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic                   accept;
  logic                   ram_we;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b, pick;
  logic                   a_left, b_left, take_a;

  logic [CALC_W-1:0] depth_c, s1_c, s2_c, l1_c, l2_c, sum_c, tot_c;
  logic [LEN_W:0]    d_inc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (in_item.opcode == OP_LOAD) &&
                  ({1'b0, in_item.load_index} < (IDX_W + 1)'(MEM_DEPTH));

  trme_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (in_item.load_index[AW-1:0]),
    .wdata  (VALUE_WIDTH'(in_item.load_value)),
    .raddr_a(a_nxt[AW-1:0]),
    .raddr_b(b_nxt[AW-1:0]),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run1_start_r  <= '0;
      run1_length_r <= '0;
      run2_start_r  <= '0;
      run2_length_r <= '0;
      dest_start_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RUN1_START:  run1_start_r  <= cfg_wdata[IDX_W-1:0];
        CFG_RUN1_LENGTH: run1_length_r <= cfg_wdata;
        CFG_RUN2_START:  run2_start_r  <= cfg_wdata[IDX_W-1:0];
        CFG_RUN2_LENGTH: run2_length_r <= cfg_wdata;
        CFG_DEST_START:  dest_start_r  <= cfg_wdata[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Runs are clamped to the end of the store and the total is capped at the
  // depth when a merge is accepted.
  always_comb begin
    depth_c = CALC_W'(MEM_DEPTH);
    s1_c    = CALC_W'(run1_start_r);
    s2_c    = CALC_W'(run2_start_r);
    if (s1_c >= depth_c) begin
      l1_c = '0;
    end else if (CALC_W'(run1_length_r) > depth_c - s1_c) begin
      l1_c = depth_c - s1_c;
    end else begin
      l1_c = CALC_W'(run1_length_r);
    end
    if (s2_c >= depth_c) begin
      l2_c = '0;
    end else if (CALC_W'(run2_length_r) > depth_c - s2_c) begin
      l2_c = depth_c - s2_c;
    end else begin
      l2_c = CALC_W'(run2_length_r);
    end
    sum_c = l1_c + l2_c;
    tot_c = (sum_c > depth_c) ? depth_c : sum_c;
  end

  assign a_left = (a_r < ea_r);
  assign b_left = (b_r < eb_r);
  assign take_a = a_left && (!b_left || ($signed(rd_a) < $signed(rd_b)));
  assign pick   = take_a ? rd_a : rd_b;
  assign d_inc  = {1'b0, d_r} + (IDX_W + 1)'(1);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.opcode == OP_MERGE)) begin
          a_nxt     = (s1_c >= depth_c) ? '0 : CW'(s1_c);
          b_nxt     = (s2_c >= depth_c) ? '0 : CW'(s2_c);
          ea_nxt    = CW'(((s1_c >= depth_c) ? '0 : s1_c) + l1_c);
          eb_nxt    = CW'(((s2_c >= depth_c) ? '0 : s2_c) + l2_c);
          rem_nxt   = CW'(tot_c);
          d_nxt     = dest_start_r;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if ({1'b0, d_r} >= (IDX_W + 1)'(MEM_DEPTH)) begin
          d_nxt = IDX_W'({1'b0, d_r} - (IDX_W + 1)'(MEM_DEPTH));
        end else if (rem_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.dest_index = d_r;
        out_item_nxt.out_value  = DATA_W'($signed(pick));
        out_item_nxt.last       = (rem_r == CW'(1));
        if (take_a) begin
          a_nxt = a_r + CW'(1);
        end else begin
          b_nxt = b_r + CW'(1);
        end
        d_nxt   = (d_inc == (IDX_W + 1)'(MEM_DEPTH)) ? '0 : IDX_W'(d_inc);
        rem_nxt = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    d_r        <= d_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_MERGE))
    else $error("A result transaction appeared without a merge step.");

  a_last_ends_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last) |-> (state_r == ST_IDLE))
    else $error("The sequencer kept merging after the last result.");

  a_merge_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (rem_r != '0) && (a_left || b_left))
    else $error("A merge step ran with no element left.");

  a_ptr_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (a_r <= ea_r) && (b_r <= eb_r))
    else $error("A run pointer passed the end of its run.");

endmodule

`default_nettype wire

### sim/two_run_merge_engine_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the two-run merge engine: follows loads, configuration writes and merge
// commands, predicts the merged results and compares every result transaction.
// Depends on trme_pkg for the transaction types and register indexes.

module two_run_merge_engine_unit_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  trme_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  trme_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [trme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trme_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              awaited,
  output int                              results_checked
);

  import trme_pkg::*;

  localparam int DEPTH = MEM_DEPTH_DEF;

  logic signed [DATA_W-1:0] shadow_store [DEPTH];
  logic [IDX_W-1:0]         run1_base;
  logic [IDX_W-1:0]         run2_base;
  logic [IDX_W-1:0]         dest_base;
  logic [LEN_W-1:0]         run1_count;
  logic [LEN_W-1:0]         run2_count;
  out_item_t                merged_q [$];
  int                       errors = 0;
  int                       checked = 0;

  function automatic int usable_len(input logic [IDX_W-1:0] first,
                                    input logic [LEN_W-1:0] count);
    return (int'(count) > DEPTH - int'(first)) ? DEPTH - int'(first) : int'(count);
  endfunction

  function automatic void predict_merge();
    int                       a;
    int                       b;
    int                       end_a;
    int                       end_b;
    int                       total;
    int                       k;
    logic signed [DATA_W-1:0] pick;
    out_item_t                res;
    a = run1_base;
    b = run2_base;
    end_a = a + usable_len(run1_base, run1_count);
    end_b = b + usable_len(run2_base, run2_count);
    total = (end_a - a) + (end_b - b);
    if (total > DEPTH) total = DEPTH;
    for (k = 0; k < total; k++) begin
      // On equal heads the second run wins.
      if (a < end_a && (b >= end_b || shadow_store[a] < shadow_store[b])) begin
        pick = shadow_store[a];
        a++;
      end else begin
        pick = shadow_store[b];
        b++;
      end
      res.dest_index = IDX_W'((int'(dest_base) + k) % DEPTH);
      res.out_value  = pick;
      res.last       = (k == total - 1);
      merged_q.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      run1_base  = '0;
      run2_base  = '0;
      dest_base  = '0;
      run1_count = '0;
      run2_count = '0;
      merged_q.delete();
    end else begin
      if (out_valid) begin
        checked++;
        if (merged_q.size() == 0) begin
          report_mismatch($sformatf(
              "result with no expectation waiting, dest_index %0d value %0d",
              out_item.dest_index, out_item.out_value));
        end else begin
          want = merged_q.pop_front();
          if (out_item.dest_index !== want.dest_index)
            report_mismatch($sformatf("dest_index got %0d expected %0d",
                                      out_item.dest_index, want.dest_index));
          if (out_item.out_value !== want.out_value)
            report_mismatch($sformatf("out_value got %0d expected %0d (dest_index %0d)",
                                      out_item.out_value, want.out_value, want.dest_index));
          if (out_item.last !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b (dest_index %0d)",
                                      out_item.last, want.last, want.dest_index));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RUN1_START:  run1_base  = cfg_wdata[IDX_W-1:0];
          CFG_RUN1_LENGTH: run1_count = cfg_wdata[LEN_W-1:0];
          CFG_RUN2_START:  run2_base  = cfg_wdata[IDX_W-1:0];
          CFG_RUN2_LENGTH: run2_count = cfg_wdata[LEN_W-1:0];
          CFG_DEST_START:  dest_base  = cfg_wdata[IDX_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.opcode == OP_LOAD) begin
          shadow_store[in_item.load_index] = in_item.load_value;
        end else begin
          predict_merge();
        end
      end
    end
    mismatch_count  <= errors;
    awaited         <= merged_q.size();
    results_checked <= checked;
  end

endmodule

### sim/two_run_merge_engine_unit_test.sv
`timescale 1ns / 1ps
// Top of the two-run merge engine testbench: clock, reset, load and merge stimulus,
// configuration between merges and the verdict. Depends on trme_pkg, the engine and
// two_run_merge_engine_unit_checker.

module two_run_merge_engine_unit_test;
  import trme_pkg::*;

  localparam int DEPTH          = MEM_DEPTH_DEF;
  localparam int ITEM_TARGET    = 460;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int awaited;
  int results_checked;
  int items_sent = 0;
  int merges_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  two_run_merge_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  two_run_merge_engine_unit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .awaited         (awaited),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction.", quiet_cycles);
      $display("two_run_merge_engine_unit_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input opcode_t op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val);
    in_item_t item;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    item.opcode     = op;
    item.load_index = idx;
    item.load_value = val;
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    burst_left--;
    items_sent++;
    if (op == OP_MERGE) merges_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy || awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] r1s, input logic [CFG_DATA_W-1:0] r1l,
                           input logic [CFG_DATA_W-1:0] r2s, input logic [CFG_DATA_W-1:0] r2l,
                           input logic [CFG_DATA_W-1:0] ds);
    settle();
    put_reg(CFG_RUN1_START, r1s);
    put_reg(CFG_RUN1_LENGTH, r1l);
    put_reg(CFG_RUN2_START, r2s);
    put_reg(CFG_RUN2_LENGTH, r2l);
    put_reg(CFG_DEST_START, ds);
    if ($urandom_range(0, 9) == 0) begin
      // An unused register index must leave every register alone.
      cfg_index <= CFG_IDX_W'(CFG_DEST_START) + CFG_IDX_W'($urandom_range(1, 3));
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic fill_run(input int first, input int count, input bit ordered);
    longint level;
    int     step_max;
    int     n;
    int     i;
    n = (count > DEPTH - first) ? DEPTH - first : count;
    case ($urandom_range(0, 3))
      0: step_max = 0;
      1: step_max = 3;
      2: step_max = 5000;
      default: step_max = 1 << 26;
    endcase
    level = ($urandom_range(0, 1) == 1) ? longint'($signed($urandom))
                                        : longint'($urandom_range(0, 20)) - 10;
    for (i = 0; i < n; i++) begin
      if (ordered) send_item(OP_LOAD, IDX_W'(first + i), DATA_W'(level));
      else send_item(OP_LOAD, IDX_W'(first + i), $urandom);
      level += $urandom_range(0, step_max);
      if (level > VAL_MAX) level = VAL_MAX;
    end
  endtask

  function automatic int pick_len();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return $urandom_range(0, 127);
      2: return DEPTH;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  initial begin : stimulus
    int r1s;
    int r1l;
    int r2s;
    int r2l;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both runs are empty after reset, so this merge returns nothing.
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);

    configure(7'd0, 7'd4, 7'd60, 7'd127, 7'd63);
    send_item(OP_LOAD, 6'd0, VAL_MIN);
    send_item(OP_LOAD, 6'd1, -32'sd1);
    send_item(OP_LOAD, 6'd2, 32'sd0);
    send_item(OP_LOAD, 6'd3, 32'sd5);
    send_item(OP_LOAD, 6'd60, -32'sd1);
    send_item(OP_LOAD, 6'd61, 32'sd5);
    send_item(OP_LOAD, 6'd62, 32'sd7);
    send_item(OP_LOAD, 6'd63, VAL_MAX);
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);

    // Runs with equal heads, the first of them unsorted, show which run wins a tie.
    configure(7'd10, 7'd2, 7'd20, 7'd2, 7'd0);
    send_item(OP_LOAD, 6'd10, 32'sd5);
    send_item(OP_LOAD, 6'd11, 32'sd1);
    send_item(OP_LOAD, 6'd20, 32'sd5);
    send_item(OP_LOAD, 6'd21, 32'sd9);
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);

    configure(7'd0, 7'd0, 7'd60, 7'd4, 7'd5);
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);
    configure(7'd0, 7'd4, 7'd0, 7'd0, 7'd1);
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);
    configure(7'd0, 7'd4, 7'd2, 7'd2, 7'd32);
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);
    configure(7'd63, 7'd1, 7'd63, 7'd1, 7'd40);
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);

    // Two full-store runs exceed the output cap.
    configure(7'd0, 7'd64, 7'd0, 7'd64, CFG_DATA_W'($urandom_range(0, 63)));
    fill_run(0, DEPTH, 1'b1);
    send_item(OP_MERGE, IDX_W'($urandom), $urandom);

    while (items_sent < ITEM_TARGET) begin
      r1s = $urandom_range(0, DEPTH - 1);
      r2s = $urandom_range(0, DEPTH - 1);
      r1l = pick_len();
      r2l = pick_len();
      configure({1'($urandom), 6'(r1s)}, 7'(r1l), {1'($urandom), 6'(r2s)}, 7'(r2l),
                {1'($urandom), 6'($urandom)});
      fill_run(r1s, r1l, $urandom_range(0, 7) != 0);
      fill_run(r2s, r2l, $urandom_range(0, 7) != 0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) send_item(OP_LOAD, IDX_W'($urandom), $urandom);
      end
      send_item(OP_MERGE, IDX_W'($urandom), $urandom);
      if ($urandom_range(0, 4) == 0) send_item(OP_MERGE, IDX_W'($urandom), $urandom);
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d transactions, %0d of them merges, with runs from empty to the full store.",
             items_sent, merges_sent);
    $display("Checked %0d merged results: %0d mismatches, %0d results never arrived.",
             results_checked, mismatch_count, awaited);
    if (mismatch_count == 0 && awaited == 0) begin
      $display("two_run_merge_engine_unit_test OK");
    end else begin
      $display("two_run_merge_engine_unit_test NOT OK");
    end
    $finish;
  end

endmodule
